// ----- sv/krt_pkg.sv -----
// Shared types and constants for the keyed record table.
// No dependencies; imported by every module of the block.
package krt_pkg;

  localparam int DEPTH      = 64;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int KEY_W      = 37;
  localparam int NAME_WORDS = 4;
  localparam int IN_DATA_W  = 376;
  localparam int OUT_DATA_W = 384;

  localparam logic [7:0]  GENDER_RESET = 8'h20;
  localparam logic [63:0] NAME_RESET   = 64'h0000_0000_4C4C_554E;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CHANGE = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_FULL      = 3'd3,
    ST_INVALID   = 3'd4
  } status_t;

  typedef struct packed {
    logic [NAME_WORDS-1:0][63:0] name;
    logic [31:0]                 salary;
    logic [7:0]                  gender;
    logic [7:0]                  age;
    logic [31:0]                 id;
  } payload_t;

  localparam payload_t PAYLOAD_RESET = '{
    name:   {64'd0, 64'd0, 64'd0, NAME_RESET},
    salary: 32'd0,
    gender: GENDER_RESET,
    age:    8'd0,
    id:     32'd0
  };

  typedef struct packed {
    logic capture;
    logic commit;
    logic load_rd;
  } cmd_t;

  typedef struct packed {
    logic rd_needed;
  } sts_t;

endpackage

// ----- sv/krt_ctrl.sv -----
// Controller for the keyed record table: sequences lookup, commit and read.
// Depends on krt_pkg; drives the datapath through cmd_t, reads sts_t.
module krt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  krt_pkg::sts_t sts,
  output krt_pkg::cmd_t cmd
);
  import krt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          if (sts.rd_needed) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_READ;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_READ: begin
        cmd.load_rd   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/krt_datapath.sv -----
// Datapath for the keyed record table: key registers with parallel compare,
// payload memory and result register. Depends on krt_pkg.
module krt_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  krt_pkg::cmd_t            cmd,
  output krt_pkg::sts_t            sts,
  input  krt_pkg::op_t             in_op,
  input  logic [krt_pkg::KEY_W-1:0] in_key,
  input  krt_pkg::payload_t        in_pay,
  output krt_pkg::status_t         res_status,
  output logic [krt_pkg::IDX_W-1:0] res_slot,
  output logic [krt_pkg::KEY_W-1:0] res_key,
  output krt_pkg::payload_t        res_pay
);
  import krt_pkg::*;

  logic [KEY_W-1:0] keys_r [DEPTH];
  payload_t         mem [DEPTH];
  payload_t         rdata_r;

  logic [DEPTH-1:0] match_vec, free_vec;
  logic             match_hit, free_hit;
  logic [IDX_W-1:0] match_idx, free_idx;

  op_t              op_r;
  logic [KEY_W-1:0] key_r;
  payload_t         pay_r;
  logic             key_zero_r, match_hit_r, free_hit_r;
  logic [IDX_W-1:0] match_idx_r, free_idx_r;

  status_t          status;
  logic [IDX_W-1:0] slot;
  logic             ok, do_write;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_vec[i] = (keys_r[i] == in_key);
      free_vec[i]  = (keys_r[i] == '0);
    end
  end

  // lowest index wins
  always_comb begin
    match_hit = 1'b0;
    free_hit  = 1'b0;
    match_idx = '0;
    free_idx  = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_hit = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (free_vec[i]) begin
        free_hit = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= in_op;
      key_r       <= in_key;
      pay_r       <= in_pay;
      key_zero_r  <= (in_key == '0);
      match_hit_r <= match_hit;
      match_idx_r <= match_idx;
      free_hit_r  <= free_hit;
      free_idx_r  <= free_idx;
    end
  end

  always_comb begin
    slot = match_idx_r;
    if (key_zero_r) begin
      status = ST_INVALID;
    end else if (op_r == OP_INSERT) begin
      slot = free_idx_r;
      if (!free_hit_r) begin
        status = ST_FULL;
      end else if (match_hit_r) begin
        status = ST_PRESENT;
      end else begin
        status = ST_OK;
      end
    end else if (!match_hit_r) begin
      status = ST_NOT_FOUND;
    end else begin
      status = ST_OK;
    end
  end

  assign ok            = (status == ST_OK);
  assign do_write      = cmd.commit && ok && (op_r == OP_INSERT || op_r == OP_CHANGE);
  assign sts.rd_needed = ok && (op_r == OP_SEARCH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        keys_r[i] <= '0;
      end
    end else if (cmd.commit && ok) begin
      if (op_r == OP_INSERT) begin
        keys_r[slot] <= key_r;
      end else if (op_r == OP_REMOVE) begin
        keys_r[slot] <= '0;
      end
    end
  end

  // payload is read only for entries holding a live key
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[slot] <= pay_r;
    end
    if (cmd.commit && sts.rd_needed) begin
      rdata_r <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rd) begin
      res_status <= ST_OK;
      res_slot   <= slot;
      res_key    <= key_r;
      res_pay    <= rdata_r;
    end else if (cmd.commit && !sts.rd_needed) begin
      res_status <= status;
      if (!ok) begin
        res_slot <= '0;
        res_key  <= '0;
        res_pay  <= '0;
      end else if (op_r == OP_REMOVE) begin
        res_slot <= slot;
        res_key  <= '0;
        res_pay  <= PAYLOAD_RESET;
      end else begin
        res_slot <= slot;
        res_key  <= key_r;
        res_pay  <= pay_r;
      end
    end
  end

endmodule

// ----- sv/keyed_record_table.sv -----
// Top level of the keyed record table: stream ports, field packing, assertions.
// Depends on krt_pkg, krt_ctrl and krt_datapath.
//
// A table of 64 records, each found by a nonzero 37-bit key. Free entries
// hold key zero. The input stream carries one operation per item (insert,
// change, remove, search); every item gives exactly one result item with a
// status, the slot touched and the entry's contents after the operation.
//
// Timing: the item is accepted while the block is idle and all 64 stored
// keys are compared against it in that same cycle. Once any earlier result
// is taken, the block commits the write and loads the result register;
// a successful search loads it in a later read state instead, since the
// payload comes from a single-port memory with a registered read.
//
// Reset clears all keys at once, so the table is empty right after reset;
// no clearing pass. A stalled receiver holds the result register; the
// block accepts the next item but will not commit it until the pending
// result has been taken.
module keyed_record_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // record_key, id_number, age_years, gender_code, salary_cents,
  // name_bytes_0, name_bytes_1, name_bytes_2, name_bytes_3
  input  logic [krt_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // slot_index, found_key, found_id_number, found_age, found_gender,
  // found_salary, found_name_0, found_name_1, found_name_2, found_name_3
  output logic [krt_pkg::OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [2:0]                     out_tuser
);
  import krt_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  op_t              in_op;
  logic [KEY_W-1:0] in_key;
  payload_t         in_pay;
  status_t          res_status;
  logic [IDX_W-1:0] res_slot;
  logic [KEY_W-1:0] res_key;
  payload_t         res_pay;

  assign in_op          = op_t'(in_tuser);
  assign in_key         = in_tdata[36:0];
  assign in_pay.id      = in_tdata[68:37];
  assign in_pay.age     = in_tdata[76:69];
  assign in_pay.gender  = in_tdata[84:77];
  assign in_pay.salary  = in_tdata[116:85];
  assign in_pay.name[0] = in_tdata[180:117];
  assign in_pay.name[1] = in_tdata[244:181];
  assign in_pay.name[2] = in_tdata[308:245];
  assign in_pay.name[3] = in_tdata[372:309];

  krt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  krt_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_op),
    .in_key     (in_key),
    .in_pay     (in_pay),
    .res_status (res_status),
    .res_slot   (res_slot),
    .res_key    (res_key),
    .res_pay    (res_pay)
  );

  assign out_tuser = res_status;
  assign out_tdata = {
    5'd0,
    res_pay.name[3],
    res_pay.name[2],
    res_pay.name[1],
    res_pay.name[0],
    res_pay.salary,
    res_pay.gender,
    res_pay.age,
    res_pay.id,
    res_key,
    res_slot
  };

  a_no_commit_on_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !cmd.commit)
    else $error("commit issued in the accept cycle");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("accepted a second item before commit");

  a_read_follows_search : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_rd |-> ($past(cmd.commit) && $past(sts.rd_needed)))
    else $error("memory read data loaded without a search hit");

  a_commit_needs_slot : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !sts.rd_needed) |=> out_tvalid)
    else $error("commit did not present a result");

endmodule
